@@ rtl/erb_pkg.sv @@
// ----------------------------------------------------------------------------
// erb_pkg
// Shared constants and controller/datapath interface types for the
// euclidean rhythm trigger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package erb_pkg;

  // longest pattern held in the pattern register
  localparam int MAX_STEPS = 64;
  // counts and lengths up to MAX_STEPS inclusive
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  // bit position within the pattern
  localparam int POS_W     = $clog2(MAX_STEPS);

  // fixed field widths
  localparam int STEP_W    = 16;
  localparam int KN_W      = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_AW    = 2;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_HIT   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_STEPS = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ROT   = 2'd2;

  // register reset values
  localparam logic [KN_W-1:0]   HIT_RST   = 7'd4;
  localparam logic [KN_W-1:0]   STEPS_RST = 7'd16;
  localparam logic [STEP_W-1:0] ROT_RST   = 16'd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mod_start;
    logic mod_sel_rot;
    logic rot_store;
    logic grp_init;
    logic grp_step;
    logic fl_step;
    logic out_load;
  } erb_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mod_done;
    logic grp_stop;
    logic fl_finish;
  } erb_sts_t;

endpackage

`default_nettype wire

@@ rtl/erb_mod.sv @@
// ----------------------------------------------------------------------------
// erb_mod
// Bit-serial remainder unit: wraps a signed 16-bit value into
// 0 .. modulus-1, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erb_mod import erb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [STEP_W-1:0] value,
  input  wire logic [CNT_W-1:0]  modulus,
  output logic                   done,
  output logic [CNT_W-1:0]       result
);

  localparam int                CW       = $clog2(STEP_W);
  localparam logic [CW-1:0]     CNT_LAST = CW'(STEP_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] mag_r, mag_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;

  // restoring step: bring in the next magnitude bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, mag_r[STEP_W-1]};
    trial_sub = trial - {1'b0, modulus};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = value[STEP_W-1];
      mag_nxt  = value[STEP_W-1] ? (~value + {{(STEP_W-1){1'b0}}, 1'b1}) : value;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, modulus}) ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      mag_nxt = {mag_r[STEP_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // working value
  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
  end

  // negative values wrap back into range
  assign done   = done_r;
  assign result = (neg_r && (rem_r != '0)) ? (modulus - rem_r) : rem_r;

endmodule

`default_nettype wire

@@ rtl/erb_dp.sv @@
// ----------------------------------------------------------------------------
// erb_dp
// Datapath: configuration registers, group builder for the rhythm pattern,
// flattening into the pattern register, and the step lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erb_dp import erb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic [STEP_W-1:0] in_step,
  input  wire erb_cmd_t          cmd,
  output erb_sts_t               sts,
  output logic                   trigger
);

  logic [KN_W-1:0]      hit_r;
  logic [KN_W-1:0]      steps_r;
  logic [STEP_W-1:0]    rot_amt_r;
  logic [STEP_W-1:0]    step_r;
  logic [CNT_W-1:0]     rot_r;

  logic [CNT_W-1:0]     a_r, a_nxt;
  logic [CNT_W-1:0]     b_r, b_nxt;
  logic [MAX_STEPS-1:0] pa_r, pa_nxt;
  logic [MAX_STEPS-1:0] pb_r, pb_nxt;
  logic [CNT_W-1:0]     la_r, la_nxt;
  logic [CNT_W-1:0]     lb_r, lb_nxt;
  logic [MAX_STEPS-1:0] pat_r, pat_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic                 trigger_r;

  logic [CNT_W-1:0]     n_eff;
  logic [STEP_W-1:0]    mod_value;
  logic                 mod_done;
  logic [CNT_W-1:0]     mod_res;
  logic [MAX_STEPS-1:0] cat;
  logic [CNT_W:0]       ab_sum;
  logic [CNT_W:0]       look_sum;
  logic [CNT_W:0]       look_sub;
  logic [CNT_W-1:0]     look_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r     <= HIT_RST;
      steps_r   <= STEPS_RST;
      rot_amt_r <= ROT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HIT:   hit_r     <= cfg_wdata[KN_W-1:0];
        CFG_STEPS: steps_r   <= cfg_wdata[KN_W-1:0];
        CFG_ROT:   rot_amt_r <= cfg_wdata[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  // step count clamped into 1 .. MAX_STEPS
  always_comb begin
    if (steps_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (steps_r > KN_W'(MAX_STEPS)) begin
      n_eff = CNT_W'(MAX_STEPS);
    end else begin
      n_eff = steps_r[CNT_W-1:0];
    end
  end

  // shared remainder unit for rotation and step index
  assign mod_value = cmd.mod_sel_rot ? rot_amt_r : step_r;

  erb_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.mod_start),
    .value   (mod_value),
    .modulus (n_eff),
    .done    (mod_done),
    .result  (mod_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      step_r <= in_step;
    end
    if (cmd.rot_store) begin
      rot_r <= mod_res;
    end
  end

  // group builder: a copies of group A then b copies of group B
  assign cat    = pa_r | (pb_r << la_r[POS_W-1:0]);
  assign ab_sum = {1'b0, a_r} + {1'b0, b_r};

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    pa_nxt  = pa_r;
    pb_nxt  = pb_r;
    la_nxt  = la_r;
    lb_nxt  = lb_r;
    pat_nxt = pat_r;
    pos_nxt = pos_r;
    if (cmd.grp_init) begin
      pos_nxt = '0;
      pa_nxt  = {{(MAX_STEPS-1){1'b0}}, 1'b1};
      pb_nxt  = '0;
      la_nxt  = CNT_W'(1);
      lb_nxt  = CNT_W'(1);
      if (hit_r == '0) begin
        // no hits: empty pattern, nothing to flatten
        a_nxt   = '0;
        b_nxt   = '0;
        pat_nxt = '0;
      end else if (hit_r >= KN_W'(n_eff)) begin
        // hits cover every step
        a_nxt   = '0;
        b_nxt   = '0;
        pat_nxt = '1;
      end else begin
        a_nxt   = hit_r[CNT_W-1:0];
        b_nxt   = n_eff - hit_r[CNT_W-1:0];
        pat_nxt = '0;
      end
    end else if (cmd.grp_step) begin
      pa_nxt = cat;
      la_nxt = la_r + lb_r;
      if (a_r <= b_r) begin
        b_nxt = b_r - a_r;
      end else begin
        // leftover B groups run out: the unpaired A groups become the new B
        pb_nxt = pa_r;
        lb_nxt = la_r;
        a_nxt  = b_r;
        b_nxt  = a_r - b_r;
      end
    end else if (cmd.fl_step) begin
      if (a_r != '0) begin
        pat_nxt = pat_r | (pa_r << pos_r[POS_W-1:0]);
        pos_nxt = pos_r + la_r;
        a_nxt   = a_r - CNT_W'(1);
      end else begin
        pat_nxt = pat_r | (pb_r << pos_r[POS_W-1:0]);
        pos_nxt = pos_r + lb_r;
        b_nxt   = b_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    la_r  <= la_nxt;
    lb_r  <= lb_nxt;
    pat_r <= pat_nxt;
    pos_r <= pos_nxt;
  end

  // lookup: (index + rotation) wrapped once
  always_comb begin
    look_sum = {1'b0, mod_res} + {1'b0, rot_r};
    look_sub = look_sum - {1'b0, n_eff};
    look_pos = (look_sum >= {1'b0, n_eff}) ? look_sub[CNT_W-1:0] : look_sum[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      trigger_r <= pat_r[look_pos[POS_W-1:0]];
    end
  end

  assign sts.mod_done  = mod_done;
  assign sts.grp_stop  = (b_r == '0) || (ab_sum <= (CNT_W+1)'(1));
  assign sts.fl_finish = (a_r == '0) && (b_r == '0);
  assign trigger       = trigger_r;

endmodule

`default_nettype wire

@@ rtl/erb_ctrl.sv @@
// ----------------------------------------------------------------------------
// erb_ctrl
// Controller: sequences pattern rebuild after configuration changes,
// the step index reduction and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erb_ctrl import erb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire logic     cfg_we,
  input  wire erb_sts_t sts,
  output erb_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RSTART = 4'd1;
  localparam logic [3:0] S_ROTW   = 4'd2;
  localparam logic [3:0] S_GINIT  = 4'd3;
  localparam logic [3:0] S_GRP    = 4'd4;
  localparam logic [3:0] S_FLAT   = 4'd5;
  localparam logic [3:0] S_ISTART = 4'd6;
  localparam logic [3:0] S_IDXW   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       dirty_r, dirty_nxt;
  logic       out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    dirty_nxt     = dirty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = dirty_r ? S_RSTART : S_ISTART;
        end
      end
      S_RSTART: begin
        cmd.mod_start   = 1'b1;
        cmd.mod_sel_rot = 1'b1;
        state_nxt       = S_ROTW;
      end
      S_ROTW: begin
        cmd.mod_sel_rot = 1'b1;
        if (sts.mod_done) begin
          cmd.rot_store = 1'b1;
          state_nxt     = S_GINIT;
        end
      end
      S_GINIT: begin
        cmd.grp_init = 1'b1;
        state_nxt    = S_GRP;
      end
      S_GRP: begin
        if (sts.grp_stop) begin
          state_nxt = S_FLAT;
        end else begin
          cmd.grp_step = 1'b1;
        end
      end
      S_FLAT: begin
        if (sts.fl_finish) begin
          dirty_nxt = 1'b0;
          state_nxt = S_ISTART;
        end else begin
          cmd.fl_step = 1'b1;
        end
      end
      S_ISTART: begin
        cmd.mod_start = 1'b1;
        state_nxt     = S_IDXW;
      end
      S_IDXW: begin
        if (sts.mod_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // any register write invalidates the cached pattern
    if (cfg_we) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/euclidean_rhythm_trigger_core.sv @@
// ----------------------------------------------------------------------------
// euclidean_rhythm_trigger_core
// Answers each step index request with whether that step of a Euclidean
// rhythm is a hit. The pattern is built from hit_count, step_count and
// rotate_amount and cached until the next register write. When the pattern
// is cached, a request is taken, the remainder is started, bit-serial
// remainder steps run over the 16 bits of the step index, the remainder
// finishes and the output register is loaded. The first request after a
// register write also rebuilds the pattern: the rotation remainder, seeding
// the groups, the grouping passes and the flattening of each group, with a
// finishing step each for grouping and flattening. Passes and flattened
// groups together never exceed the step count. A new request is taken
// while the previous result still waits in the output register; its own
// result then waits until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module euclidean_rhythm_trigger_core import erb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request: step_index[15:0]
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,
  // result: trigger[0], zeros above
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  // register writes
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  erb_cmd_t cmd;
  erb_sts_t sts;
  logic     trigger;

  erb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .sts        (sts),
    .cmd        (cmd)
  );

  erb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_step   (in_tdata[STEP_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .trigger   (trigger)
  );

  assign out_tdata = {7'd0, trigger};

endmodule

`default_nettype wire

@@ rtl/erb_checker.sv @@
// ----------------------------------------------------------------------------
// erb_checker
// Port-level checks on the rhythm trigger core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module erb_checker import erb_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [7:0]        out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: busy right after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");

  // reset leaves the block ready with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("bad state after reset");

  // a new result only appears at the end of a request's work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without a request in progress");

endmodule

bind euclidean_rhythm_trigger_core erb_checker u_erb_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the euclidean rhythm trigger core. Step index
// requests are streamed in with random gaps under a series of register
// settings. Each accepted request is predicted by an independent Bjorklund
// pattern builder, and the predictions are compared in order against the
// returned trigger bits while the output side stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// register mirror, trigger prediction and in-order result checking
class trigger_scoreboard;
  typedef struct {
    logic [15:0] step;
    logic [7:0]  tdata;
  } trigger_req_t;

  localparam int HIT_CAP = 64;

  logic [6:0]   hit_reg;
  logic [6:0]   step_reg;
  logic [15:0]  rot_reg;
  trigger_req_t awaited[$];
  int unsigned  requests;
  int unsigned  checked;
  int unsigned  mismatches;

  function new();
    hit_reg    = erb_pkg::HIT_RST;
    step_reg   = erb_pkg::STEPS_RST;
    rot_reg    = erb_pkg::ROT_RST;
    requests   = 0;
    checked    = 0;
    mismatches = 0;
  endfunction

  // mirror of a register write, unknown indexes leave everything alone
  function void set_reg(logic [erb_pkg::CFG_AW-1:0] idx, logic [erb_pkg::CFG_W-1:0] value);
    case (idx)
      erb_pkg::CFG_HIT:   hit_reg  = value[6:0];
      erb_pkg::CFG_STEPS: step_reg = value[6:0];
      erb_pkg::CFG_ROT:   rot_reg  = value[15:0];
      default: ;
    endcase
  endfunction

  // signed value folded into 0 .. n-1
  function int unsigned wrap_into(logic signed [15:0] v, int unsigned n);
    int r;
    r = int'(v);
    r = r % int'(n);
    if (r < 0) r += int'(n);
    return int'(r);
  endfunction

  // unrotated rhythm, bit i is step i
  function logic [63:0] build_rhythm(int unsigned k, int unsigned n);
    logic [63:0] grp_bits [erb_pkg::MAX_STEPS];
    int unsigned grp_len [erb_pkg::MAX_STEPS];
    int unsigned groups;
    int unsigned spare_groups;
    int unsigned pairs;
    int unsigned last;
    int unsigned pos;
    logic [63:0] pat;
    if (k == 0) return 64'd0;
    if (k >= n) return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    for (int unsigned i = 0; i < n; i++) begin
      grp_bits[i] = (i < k) ? 64'd1 : 64'd0;
      grp_len[i]  = 1;
    end
    groups = n;
    // fold the tail groups onto the head groups until the remainder runs out
    while (groups > 1 && groups > k) begin
      spare_groups = groups - k;
      pairs = (k < spare_groups) ? k : spare_groups;
      for (int unsigned i = 0; i < pairs; i++) begin
        last = groups - 1;
        grp_bits[i] |= grp_bits[last] << (grp_len[i] & 63);
        grp_len[i] += grp_len[last];
        groups--;
      end
      k = pairs;
    end
    // flatten in order
    pat = 64'd0;
    pos = 0;
    for (int unsigned i = 0; i < groups; i++) begin
      if (pos < 64) pat |= grp_bits[i] << pos;
      pos += grp_len[i];
    end
    return pat;
  endfunction

  function logic predict_trigger(logic [15:0] step);
    int unsigned n;
    int unsigned k;
    int unsigned rot;
    int unsigned idx;
    logic [63:0] pat;
    n = step_reg;
    k = hit_reg;
    if (n < 1) n = 1;
    if (n > erb_pkg::MAX_STEPS) n = erb_pkg::MAX_STEPS;
    if (k > HIT_CAP) k = HIT_CAP;
    pat = build_rhythm(k, n);
    rot = wrap_into(rot_reg, n);
    idx = wrap_into(step, n);
    return pat[(idx + rot) % n];
  endfunction

  function void note_step(logic [15:0] step);
    trigger_req_t req;
    req.step  = step;
    req.tdata = {7'd0, predict_trigger(step)};
    awaited = {awaited, req};
    requests++;
  endfunction

  function void check_trigger(logic [7:0] tdata);
    trigger_req_t req;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected trigger result %b with no request pending", $time, tdata);
      mismatches++;
      return;
    end
    req = awaited.pop_front();
    checked++;
    if (tdata !== req.tdata) begin
      $display("%0t: trigger mismatch for step %0d: expected %b, got %b",
               $time, $signed(req.step), req.tdata, tdata);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return awaited.size();
  endfunction
endclass

module tb_top;
  import erb_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
  localparam int ITEMS       = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL  = 200;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;

  trigger_scoreboard sb;

  bit          out_burst;
  int unsigned hold_req;
  int unsigned hold_count;
  int unsigned pause_count;
  int unsigned setting_count;
  int unsigned run_left;
  logic [15:0] run_next;
  int unsigned cycle_count;

  euclidean_rhythm_trigger_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // mostly counting sequencer runs, some single random positions
  function automatic logic [15:0] next_sequencer_step();
    int signed start;
    if (run_left == 0) begin
      if ($urandom_range(0, 9) < 3) return 16'($urandom);
      run_left = $urandom_range(4, 24);
      start = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 200)) - 100;
      run_next = start[15:0];
    end
    run_left--;
    run_next = run_next + 16'd1;
    return run_next - 16'd1;
  endfunction

  // one step request, with a random gap in front
  task automatic send_step(input logic [15:0] step, input bit burst);
    int unsigned gap;
    gap = draw_gap(burst);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= step;
    do @(posedge clk); while (!in_tready);
    sb.note_step(step);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // stop the sender and let every result come back before touching registers
  task automatic settle();
    park_input();
    wait_drain();
    repeat (4) @(negedge clk);
  endtask

  // back-to-back register writes, selected by which[hit, steps, rot]
  task automatic apply_settings(input logic [6:0] hit, input logic [6:0] steps,
                                input logic [15:0] rot, input logic [2:0] which,
                                input bit spare);
    bit wrote;
    logic [CFG_W-1:0] junk;
    wrote = 1'b0;
    junk  = 16'($urandom);
    if (which[0]) begin
      @(negedge clk);
      cfg_we <= 1'b1; cfg_addr <= CFG_HIT; cfg_wdata <= {9'd0, hit};
      sb.set_reg(CFG_HIT, {9'd0, hit});
      wrote = 1'b1;
    end
    if (which[1]) begin
      @(negedge clk);
      cfg_we <= 1'b1; cfg_addr <= CFG_STEPS; cfg_wdata <= {9'd0, steps};
      sb.set_reg(CFG_STEPS, {9'd0, steps});
      wrote = 1'b1;
    end
    if (which[2]) begin
      @(negedge clk);
      cfg_we <= 1'b1; cfg_addr <= CFG_ROT; cfg_wdata <= rot;
      sb.set_reg(CFG_ROT, rot);
      wrote = 1'b1;
    end
    // the unused index must be ignored
    if (spare) begin
      @(negedge clk);
      cfg_we <= 1'b1; cfg_addr <= CFG_SPARE; cfg_wdata <= junk;
      sb.set_reg(CFG_SPARE, junk);
      wrote = 1'b1;
    end
    if (wrote) begin
      @(negedge clk);
      cfg_we <= 1'b0;
    end
    setting_count++;
  endtask

  // random settings, leaning on the clamp and all-hit corners
  task automatic random_settings();
    logic [6:0]  steps_v;
    logic [6:0]  hit_v;
    logic [15:0] rot_v;
    int unsigned n_eff;
    int signed   offset;
    case ($urandom_range(0, 9))
      0:       steps_v = 7'd0;
      1:       steps_v = 7'($urandom_range(65, 127));
      2:       steps_v = 7'd64;
      3:       steps_v = 7'd1;
      default: steps_v = 7'($urandom_range(2, 64));
    endcase
    n_eff = (steps_v == 0) ? 1 : ((steps_v > 64) ? 64 : steps_v);
    case ($urandom_range(0, 9))
      0:       hit_v = 7'd0;
      1:       hit_v = 7'($urandom_range(65, 127));
      2:       hit_v = 7'(n_eff);
      3:       hit_v = 7'd64;
      default: hit_v = 7'($urandom_range(1, n_eff));
    endcase
    case ($urandom_range(0, 3))
      0:       rot_v = 16'd0;
      1:       rot_v = 16'($urandom);
      default: begin
        offset = int'($urandom_range(0, 2 * n_eff)) - int'(n_eff);
        rot_v  = offset[15:0];
      end
    endcase
    apply_settings(hit_v, steps_v, rot_v, 3'($urandom_range(1, 7)), $urandom_range(0, 4) == 0);
  endtask

  // output side: random stalls, occasionally one long hold-off
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_count < hold_req) begin
        stall = HOLD_CYCLES;
        hold_count++;
      end else begin
        stall = draw_gap(out_burst);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_trigger(out_tdata);
    end
  end

  // stimulus
  initial begin
    logic [15:0] probe[$];
    int unsigned phase;
    int unsigned len;
    int unsigned pause_at;
    bit in_burst;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 16'd0;
    cfg_we        = 1'b0;
    cfg_addr      = CFG_HIT;
    cfg_wdata     = 16'd0;
    out_burst     = 1'b0;
    hold_req      = 0;
    pause_count   = 0;
    setting_count = 0;
    run_left      = 0;
    run_next      = 16'd0;
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: wrap points and the index extremes
    probe = '{16'd0, 16'd1, 16'd4, 16'd15, 16'd16, 16'd17, 16'hFFFF, 16'h7FFF, 16'h8000};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // no hits at all, most negative rotation
    settle();
    apply_settings(7'd0, 7'd64, 16'h8000, 3'b111, 1'b0);
    probe = '{16'h5555, 16'hAAAA};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // hits above the cap with a zero step count: single always-hit step
    settle();
    apply_settings(7'd127, 7'd0, 16'h7FFF, 3'b111, 1'b0);
    probe = '{16'd0, 16'hFFFF};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // step count above the maximum clamps to 64
    settle();
    apply_settings(7'd5, 7'd127, 16'h7FFF, 3'b111, 1'b0);
    probe = '{16'd0, 16'd63, 16'hFFC0};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // three in eight with a negative rotation, plus a write to the spare index
    settle();
    apply_settings(7'd3, 7'd8, 16'hFFFF, 3'b111, 1'b1);
    probe = '{16'd0, 16'd3, 16'd6};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // one rest in 64: the lone leftover group folds into the first
    settle();
    apply_settings(7'd63, 7'd64, 16'd0, 3'b111, 1'b0);
    probe = '{16'd0, 16'd1, 16'd63};
    foreach (probe[i]) send_step(probe[i], 1'b0);

    // hits equal steps at the largest size
    settle();
    apply_settings(7'd64, 7'd64, 16'd1, 3'b111, 1'b0);
    send_step(16'd5, 1'b0);

    // random phases
    phase = 0;
    while (sb.requests < ITEMS) begin
      phase++;
      settle();
      if ($urandom_range(0, 5) != 0) random_settings();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      // output held off while requests keep coming, so the input backs up
      if (phase == 1 || $urandom_range(0, 9) == 0) begin
        hold_req++;
        in_burst = 1'b1;
      end
      len = $urandom_range(20, 60);
      pause_at = (phase == 2 || $urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : len;
      for (int unsigned j = 0; j < len; j++) begin
        if (j == pause_at) begin
          park_input();
          wait_drain();
          pause_count++;
        end
        send_step(next_sequencer_step(), in_burst);
      end
    end

    // let the last results come back, then watch for strays
    park_input();
    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run covered %0d step requests under %0d register settings",
             sb.requests, setting_count);
    $display("with %0d long output hold-offs, %0d input pauses, %0d mismatches",
             hold_count, pause_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
